// ===== design/glpc_pkg.sv =====
// ----------------------------------------------------------------------------
// glpc_pkg
// Shared widths, the token that travels along the cell chain, and the
// controller state type for the lattice path counter.
// ----------------------------------------------------------------------------
package glpc_pkg;

  // Field widths fixed by the item format
  localparam int QueryW  = 5;   // row / column index
  localparam int CountW  = 59;  // path count
  localparam int HeightW = 6;   // filled entries per column

  // One row of the wavefront, moving one cell to the right per cycle
  typedef struct packed {
    logic              valid;
    logic [QueryW-1:0] row;
    logic [CountW-1:0] count;  // left neighbor going in, own entry coming out
  } tok_t;

  // Controller states
  typedef enum logic [1:0] {
    StIdle,
    StLaunch,
    StDrain
  } glpc_state_e;

endpackage

// ===== design/glpc_cell.sv =====
// ----------------------------------------------------------------------------
// glpc_cell
// One grid column. Holds the column's stored path counts, its filled height
// and the topmost filled entry. A row token entering from the left either
// picks up the stored entry or fills it as left + above, then moves right.
// ----------------------------------------------------------------------------
module glpc_cell import glpc_pkg::*; #(
  parameter int COL   = 0,
  parameter int DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tok_t              tok_i,
  input  logic [QueryW-1:0] peek_row_i,  // row arriving here next cycle
  input  logic [QueryW-1:0] lim_i,       // last column of the query
  output tok_t              tok_o,
  output logic [QueryW-1:0] peek_row_o
);

  localparam int  AddrW    = $clog2(DEPTH);
  localparam bit  IsOrigin = (COL == 0);

  logic [CountW-1:0]  mem_q [DEPTH];
  logic [CountW-1:0]  rd_q;
  logic [CountW-1:0]  top_q, top_d;
  logic [HeightW-1:0] h_q, h_d;
  logic               tok_vld_q;
  logic [QueryW-1:0]  tok_row_q;
  logic [CountW-1:0]  tok_cnt_q, tok_cnt_d;

  logic               active;
  logic               filled;
  logic               do_fill;
  logic [CountW-1:0]  up;
  logic [CountW-1:0]  sum;
  logic [CountW-1:0]  stored;

  // next cell looks one token ahead for its memory read
  assign peek_row_o = tok_i.row;

  // column takes part only up to the queried column
  assign active  = tok_i.valid && (QueryW'(COL) <= lim_i);
  assign filled  = HeightW'(tok_i.row) < h_q;
  assign do_fill = active && !filled;

  // new entry: above plus left, zero above the top row
  assign up  = (tok_i.row == '0) ? '0 : top_q;
  assign sum = up + tok_i.count;

  // origin entry is never written, it is one by definition
  assign stored = (IsOrigin && tok_i.row == '0) ? CountW'(1) : rd_q;

  always_comb begin
    tok_cnt_d = tok_i.count;
    top_d     = top_q;
    h_d       = h_q;
    if (active) begin
      tok_cnt_d = filled ? stored : sum;
    end
    if (do_fill) begin
      top_d = sum;
      h_d   = HeightW'(tok_i.row) + HeightW'(1);
    end
  end

  // column store, read address taken from the look-ahead row
  always_ff @(posedge clk_i) begin
    if (do_fill) begin
      mem_q[tok_i.row[AddrW-1:0]] <= sum;
    end
    rd_q <= mem_q[peek_row_i[AddrW-1:0]];
  end

  // fill state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q       <= HeightW'(IsOrigin);
      top_q     <= CountW'(IsOrigin);
      tok_vld_q <= 1'b0;
    end else begin
      h_q       <= h_d;
      top_q     <= top_d;
      tok_vld_q <= tok_i.valid;
    end
  end

  // token payload to the right neighbor
  always_ff @(posedge clk_i) begin
    tok_row_q <= tok_i.row;
    tok_cnt_q <= tok_cnt_d;
  end

  assign tok_o.valid = tok_vld_q;
  assign tok_o.row   = tok_row_q;
  assign tok_o.count = tok_cnt_q;

endmodule

// ===== design/grid_lattice_path_counter_top.sv =====
// ----------------------------------------------------------------------------
// grid_lattice_path_counter_top
// Number of monotone lattice paths from the origin to a grid position, kept
// in a memo table spread over a chain of column cells.
//
//   channel   direction  signals
//   query     in         start, busy, query_row_i, query_column_i
//   result    out        result_valid_o, path_count_o
//
// An in-grid query launches row tokens 0 to query_row into the chain, one per
// cycle, and the result strobe comes once the queried row's token has crossed
// all COLS cells, one cell per cycle (COLS = number of column cells, 32 by
// default). A query outside the grid gives zero in the next cycle. Reset
// leaves only the origin filled. The receiver cannot stall; for an in-grid
// query busy is high from acceptance until the result cycle.
// ----------------------------------------------------------------------------
module grid_lattice_path_counter_top import glpc_pkg::*; #(
  parameter int GRID_SIZE = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [QueryW-1:0] query_row_i,
  input  logic [QueryW-1:0] query_column_i,
  output logic              result_valid_o,
  output logic [CountW-1:0] path_count_o
);

  // rows and columns reachable with the index width
  localparam int Cols = (GRID_SIZE > (1 << QueryW)) ? (1 << QueryW) : GRID_SIZE;

  glpc_state_e       state_q, state_d;
  logic [QueryW-1:0] qr_q, qr_d;
  logic [QueryW-1:0] qc_q, qc_d;
  logic [QueryW-1:0] cnt_q, cnt_d;
  tok_t              launch_q, launch_d;
  logic              res_vld_q, res_vld_d;
  logic [CountW-1:0] res_cnt_q, res_cnt_d;

  logic              accept;
  logic              in_grid;
  logic              done;

  tok_t              chain [Cols+1];
  logic [QueryW-1:0] peek  [Cols];

  assign accept  = start && !busy;
  assign in_grid = (32'(query_row_i) < GRID_SIZE) && (32'(query_column_i) < GRID_SIZE);
  assign done    = chain[Cols].valid && (chain[Cols].row == qr_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && in_grid) state_d = StLaunch;
      end
      StLaunch: begin
        if (cnt_q == qr_q) state_d = StDrain;
      end
      StDrain: begin
        if (done) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    busy           = (state_q != StIdle);
    qr_d           = qr_q;
    qc_d           = qc_q;
    cnt_d          = cnt_q;
    launch_d.valid = 1'b0;
    launch_d.row   = cnt_q;
    launch_d.count = '0;
    res_vld_d      = 1'b0;
    res_cnt_d      = res_cnt_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          qr_d  = query_row_i;
          qc_d  = query_column_i;
          cnt_d = '0;
          if (!in_grid) begin
            res_vld_d = 1'b1;
            res_cnt_d = '0;
          end
        end
      end
      StLaunch: begin
        launch_d.valid = 1'b1;
        cnt_d          = cnt_q + QueryW'(1);
      end
      StDrain: begin
        if (done) begin
          res_vld_d = 1'b1;
          res_cnt_d = chain[Cols].count;
        end
      end
      default: ;
    endcase
  end

  // control registers and the launch token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      launch_q  <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      launch_q  <= launch_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    qr_q      <= qr_d;
    qc_q      <= qc_d;
    cnt_q     <= cnt_d;
    res_cnt_q <= res_cnt_d;
  end

  // column cell chain
  assign chain[0] = launch_q;
  assign peek[0]  = launch_d.row;

  for (genvar c = 0; c < Cols; c++) begin : g_cell
    if (c < Cols - 1) begin : g_mid
      glpc_cell #(
        .COL   (c),
        .DEPTH (Cols)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .tok_i      (chain[c]),
        .peek_row_i (peek[c]),
        .lim_i      (qc_q),
        .tok_o      (chain[c+1]),
        .peek_row_o (peek[c+1])
      );
    end else begin : g_last
      glpc_cell #(
        .COL   (c),
        .DEPTH (Cols)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .tok_i      (chain[c]),
        .peek_row_i (peek[c]),
        .lim_i      (qc_q),
        .tok_o      (chain[c+1]),
        .peek_row_o ()
      );
    end
  end

  assign result_valid_o = res_vld_q;
  assign path_count_o   = res_cnt_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for grid_lattice_path_counter_top. Queries are driven
// through the start/busy handshake and every answer is compared against a
// local memo-table predictor that fills missing entries in the same
// dependency order as the block. Stimulus grows the queried region slowly so
// that most items fill a partial set of new entries. Only the full-grid
// corner is left for the end, because reset happens once and a full table
// would leave nothing to fill.
// ----------------------------------------------------------------------------
module tb_top;
  import glpc_pkg::*;

  localparam int Grid        = 32;
  localparam int RandomItems = 540;
  localparam int DrainCycles = 80;       // extra wait after the sender has drained
  localparam int CycleLimit  = 400000;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [QueryW-1:0] query_row_i;
  logic [QueryW-1:0] query_column_i;
  logic              result_valid_o;
  logic [CountW-1:0] path_count_o;

  // Predictor state: memo table and the filled prefix length of each row
  logic [CountW-1:0]  path_memo [Grid][Grid];
  logic [HeightW-1:0] row_filled [Grid];

  logic [CountW-1:0] expected_counts [$];
  int                cycle_count;
  int                error_count;
  int                query_count;
  int                filling_query_count;
  int                most_fills;
  int                result_count;

  grid_lattice_path_counter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .query_row_i    (query_row_i),
    .query_column_i (query_column_i),
    .result_valid_o (result_valid_o),
    .path_count_o   (path_count_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Fill every missing entry of rows 0..row up to col, then read the answer
  function automatic logic [CountW-1:0] predict_paths(input int row, input int col,
                                                      output int fills);
    logic [CountW-1:0] up;
    logic [CountW-1:0] left;
    fills = 0;
    if (row >= Grid || col >= Grid) return '0;
    for (int r = 0; r <= row; r++) begin
      for (int c = int'(row_filled[r]); c <= col; c++) begin
        up   = (r == 0) ? '0 : path_memo[r-1][c];
        left = (c == 0) ? '0 : path_memo[r][c-1];
        path_memo[r][c] = up + left;
        row_filled[r]   = HeightW'(c + 1);
        fills++;
      end
    end
    return path_memo[row][col];
  endfunction

  // Result checker: one strobe, one expectation
  always @(posedge clk_i) begin : check_result
    logic [CountW-1:0] want;
    if (rst_ni && result_valid_o) begin
      result_count++;
      if (expected_counts.size() == 0) begin
        $error("path_count: no result expected, actual %0d", path_count_o);
        error_count++;
      end else begin
        want = expected_counts.pop_front();
        if (path_count_o !== want) begin
          $error("path_count mismatch: expected %0d, actual %0d", want, path_count_o);
          error_count++;
        end
      end
    end
  end

  // Present one query and hold it until the block takes it
  task automatic send_query(input int row, input int col);
    int                fills;
    logic [CountW-1:0] prediction;
    @(negedge clk_i);
    start          = 1'b1;
    query_row_i    = QueryW'(row);
    query_column_i = QueryW'(col);
    do @(posedge clk_i); while (busy);
    prediction      = predict_paths(row, col, fills);
    expected_counts = {expected_counts, prediction};
    query_count++;
    if (fills > 0) filling_query_count++;
    if (fills > most_fills) most_fills = fills;
  endtask

  // Sender idle for a number of cycles
  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Mostly back-to-back or short gaps, occasionally a long one
  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 90);
  endfunction

  // Hold the sender until every answer is back
  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
  endtask

  // Edges of the grid, small fills, partial rows and cached positions
  task automatic test_directed_edges();
    send_query(0, 0);    // origin, filled at reset
    send_query(0, 1);
    send_query(1, 0);
    send_query(0, 0);
    send_query(1, 1);
    send_query(2, 3);
    send_query(3, 2);    // upper rows already longer than this one
    send_query(0, 31);   // whole first row
    send_query(31, 0);   // whole first column
    idle_sender(random_gap());
    send_query(5, 5);
    send_query(5, 5);    // already filled, read only
    send_query(4, 10);
    send_query(10, 4);
    send_query(16, 1);
    send_query(1, 16);
    send_query(8, 8);
    send_query(2, 2);
    send_query(31, 1);
    send_query(1, 31);
  endtask

  // Random queries over a region that grows through the phase
  task automatic test_random_growth();
    int reach;
    int pick;
    int row;
    int col;
    for (int i = 0; i < RandomItems; i++) begin
      reach = 2 + (i * 29) / (RandomItems * 3 / 4);
      if (reach > 30) reach = 30;
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        row = $urandom_range(0, reach);
        col = $urandom_range(0, reach);
      end else if (pick < 88) begin
        row = $urandom_range(0, 3);
        col = $urandom_range(0, 3);
      end else if (pick < 94) begin
        row = 31;
        col = $urandom_range(0, reach);
      end else begin
        row = $urandom_range(0, reach);
        col = 31;
      end
      send_query(row, col);
      if ($urandom_range(0, 99) < 3) wait_drained();
      else idle_sender(random_gap());
    end
  endtask

  // Far corner fills the rest of the table; then cached reads everywhere
  task automatic test_full_grid();
    wait_drained();
    send_query(31, 31);
    send_query(31, 31);
    send_query(30, 31);
    send_query(31, 30);
    send_query(0, 0);
    send_query(17, 23);
    send_query(15, 15);
  endtask

  // Sequence
  initial begin
    rst_ni              = 1'b0;
    start               = 1'b0;
    query_row_i         = '0;
    query_column_i      = '0;
    cycle_count         = 0;
    error_count         = 0;
    query_count         = 0;
    filling_query_count = 0;
    most_fills          = 0;
    result_count        = 0;
    for (int r = 0; r < Grid; r++) begin
      row_filled[r] = '0;
      for (int c = 0; c < Grid; c++) path_memo[r][c] = '0;
    end
    path_memo[0][0] = CountW'(1);
    row_filled[0]   = HeightW'(1);

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_edges();
    test_random_growth();
    test_full_grid();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_counts.size() != 0) begin
      $error("path_count: %0d results never arrived", expected_counts.size());
      error_count++;
    end

    $display("Covered %0d queries, %0d answered; %0d filled new entries (up to %0d at once).",
             query_count, result_count, filling_query_count, most_fills);
    $display("The rest were read from filled entries; the run ended with the table full.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/glpc_pkg.sv
design/glpc_cell.sv
design/grid_lattice_path_counter_top.sv
tb/tb_top.sv
